// ===== src/scrlb_pkg.sv =====
// Package for the scrollback line ring buffer.
// Holds ring size constants, character codes, the result word type and pointer helpers.
// No dependencies.
`default_nettype none

package scrlb_pkg;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned MAX_READ  = 64;
  localparam int unsigned SPW       = $clog2(MAX_READ + 1);
  localparam int unsigned LENW      = 6;
  localparam int unsigned TOTW      = 12;

  localparam logic [7:0]      CH_CR     = 8'd13;
  localparam logic [7:0]      CH_LF     = 8'd10;
  localparam logic [TOTW-1:0] TOTAL_MAX = '1;

  typedef logic [AW-1:0] ptr_t;

  typedef struct packed {
    logic [7:0]      out_char;
    logic            last;
    logic            found;
    logic [LENW-1:0] line_length;
    logic [TOTW-1:0] line_total;
  } res_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    ptr_t r;
    if (p == '0) r = ptr_t'(DEPTH - 1);
    else r = p - ptr_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/scrollback_line_ring_buffer.sv =====
// Scrollback line ring buffer: read-modify-write controller around a 4096-byte ring.
// Append: CR is dropped; another byte evicts the oldest line if full and is written
// with a zero guard after it. Read: walks back to the line start, copies out and
// waits on output stalls; each read word leaves through a one-word output register.
// Reset: pointers and line count cleared; the text store keeps its contents.
// Depends on scrlb_pkg, scrlb_ram, scrlb_out.
`default_nettype none

module scrollback_line_ring_buffer
  import scrlb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            kind_i,
  input  wire logic [7:0]      char_in_i,
  input  wire logic [11:0]     line_back_i,
  input  wire logic [6:0]      max_chars_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 last_o,
  output logic                 found_o,
  output logic [LENW-1:0]      line_length_o,
  output logic [TOTW-1:0]      line_total_o
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_EV_RD  = 11'b000_0000_0010,
    ST_EV_DAT = 11'b000_0000_0100,
    ST_AP_WR  = 11'b000_0000_1000,
    ST_AP_GRD = 11'b000_0001_0000,
    ST_RW_CHK = 11'b000_0010_0000,
    ST_RW_DAT = 11'b000_0100_0000,
    ST_NF     = 11'b000_1000_0000,
    ST_CP_CHK = 11'b001_0000_0000,
    ST_CP_DAT = 11'b010_0000_0000,
    ST_CP_END = 11'b100_0000_0000
  } state_e;

  state_e          state_q, state_d;
  ptr_t            wp_q, wp_d, old_q, old_d, pos_q, pos_d, begin_q, begin_d;
  logic [TOTW-1:0] total_q, total_d, back_q, back_d;
  logic [SPW-1:0]  space_q, space_d;
  logic [LENW-1:0] len_q, len_d;
  logic            skip_q, skip_d, have_q, have_d;
  logic [7:0]      chr_q, chr_d;

  logic            mem_we, mem_re;
  ptr_t            mem_addr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic            emit, slot_free;
  res_t            res;
  logic            in_acc;
  logic [TOTW-1:0] back_dec;

  scrlb_ram #(
    .Depth (DEPTH),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  scrlb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .res_i         (res),
    .slot_free_o   (slot_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_o        (last_o),
    .found_o       (found_o),
    .line_length_o (line_length_o),
    .line_total_o  (line_total_o)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign back_dec   = back_q - TOTW'(1);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    old_d     = old_q;
    pos_d     = pos_q;
    begin_d   = begin_q;
    total_d   = total_q;
    back_d    = back_q;
    space_d   = space_q;
    len_d     = len_q;
    skip_d    = skip_q;
    have_d    = have_q;
    chr_d     = chr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wp_q;
    mem_wdata = chr_q;
    emit      = 1'b0;
    res       = '{out_char: 8'd0, last: 1'b1, found: 1'b1, line_length: len_q,
                  line_total: total_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!kind_i) begin
            if (char_in_i != CH_CR) begin
              chr_d = char_in_i;
              if (char_in_i == CH_LF) begin
                chr_d = 8'd0;
                if (total_q != TOTAL_MAX) total_d = total_q + TOTW'(1);
              end
              state_d = (ring_next(wp_q) == old_q) ? ST_EV_RD : ST_AP_WR;
            end
          end else begin
            back_d  = line_back_i;
            space_d = (max_chars_i > 7'(MAX_READ)) ? SPW'(MAX_READ) : SPW'(max_chars_i);
            pos_d   = wp_q;
            begin_d = '0;
            skip_d  = 1'b1;
            have_d  = 1'b0;
            len_d   = '0;
            state_d = ST_RW_CHK;
          end
        end
      end
      ST_EV_RD: begin
        if (old_q == wp_q) begin
          state_d = ST_AP_WR;
        end else begin
          mem_re   = 1'b1;
          mem_addr = old_q;
          state_d  = ST_EV_DAT;
        end
      end
      ST_EV_DAT: begin
        old_d = ring_next(old_q);
        if (mem_rdata == 8'd0) begin
          if (total_q != '0) total_d = total_q - TOTW'(1);
          state_d = ST_AP_WR;
        end else begin
          state_d = ST_EV_RD;
        end
      end
      ST_AP_WR: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q;
        mem_wdata = chr_q;
        wp_d      = ring_next(wp_q);
        state_d   = ST_AP_GRD;
      end
      ST_AP_GRD: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q;
        mem_wdata = 8'd0;
        state_d   = ST_IDLE;
      end
      ST_RW_CHK: begin
        if (pos_q != old_q && back_q != '0) begin
          pos_d    = ring_prev(pos_q);
          mem_re   = 1'b1;
          mem_addr = ring_prev(pos_q);
          state_d  = ST_RW_DAT;
        end else if (back_q == TOTW'(1) && have_q) begin
          pos_d   = begin_q;
          state_d = ST_CP_CHK;
        end else begin
          state_d = ST_NF;
        end
      end
      ST_RW_DAT: begin
        if (!skip_q && mem_rdata == 8'd0 && back_dec == '0) begin
          pos_d   = begin_q;
          state_d = ST_CP_CHK;
        end else begin
          if (!skip_q && mem_rdata == 8'd0) back_d = back_dec;
          skip_d  = 1'b0;
          begin_d = pos_q;
          have_d  = 1'b1;
          state_d = ST_RW_CHK;
        end
      end
      ST_NF: begin
        res.found       = 1'b0;
        res.line_length = '0;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CP_CHK: begin
        if (pos_q != wp_q && space_q > SPW'(1)) begin
          mem_re   = 1'b1;
          mem_addr = pos_q;
          space_d  = space_q - SPW'(1);
          state_d  = ST_CP_DAT;
        end else begin
          state_d = ST_CP_END;
        end
      end
      ST_CP_DAT: begin
        if (mem_rdata != 8'd0) begin
          res.out_char    = mem_rdata;
          res.last        = 1'b0;
          res.line_length = '0;
        end
        if (slot_free) begin
          emit = 1'b1;
          if (mem_rdata == 8'd0) begin
            state_d = ST_IDLE;
          end else begin
            len_d   = len_q + LENW'(1);
            pos_d   = ring_next(pos_q);
            state_d = ST_CP_CHK;
          end
        end
      end
      ST_CP_END: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      old_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      old_q   <= old_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    begin_q <= begin_d;
    back_q  <= back_d;
    space_q <= space_d;
    len_q   <= len_d;
    skip_q  <= skip_d;
    have_q  <= have_d;
    chr_q   <= chr_d;
  end

  a_evict_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EV_DAT |-> old_q != wp_q)
    else $error("eviction read past write pointer");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result word emitted into a full output register");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> line_length_o == '0 && found_o)
    else $error("line length on a non-final word");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && out_char_o == 8'd0)
    else $error("not-found word malformed");

  a_total_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CP_DAT |=> $stable(total_q))
    else $error("line count changed during a read");

endmodule

`default_nettype wire

// ===== src/scrlb_ram.sv =====
// Single-port synchronous byte store, one access per cycle.
// Read data is registered and holds until the next read. No dependencies.
`default_nettype none

module scrlb_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/scrlb_out.sv =====
// Output register for result words; decouples the controller from the stall.
// Depends on scrlb_pkg.
`default_nettype none

module scrlb_out
  import scrlb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                emit_i,
  input  wire res_t                res_i,
  output logic                     slot_free_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               out_char_o,
  output logic                     last_o,
  output logic                     found_o,
  output logic [LENW-1:0]          line_length_o,
  output logic [TOTW-1:0]          line_total_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = res_q.out_char;
  assign last_o        = res_q.last;
  assign found_o       = res_q.found;
  assign line_length_o = res_q.line_length;
  assign line_total_o  = res_q.line_total;

endmodule

`default_nettype wire

// ===== bench/scrlb_checker.sv =====
// Checker for the scrollback line ring buffer: watches both channels, keeps its own
// copy of the ring, pointers and line count, and compares every read word in order.
// Depends on scrlb_pkg for widths, character codes and the result word type.
`timescale 1ns / 1ps

module scrlb_checker
  import scrlb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            kind_i,
  input  logic [7:0]      char_in_i,
  input  logic [11:0]     line_back_i,
  input  logic [6:0]      max_chars_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [7:0]      out_char_i,
  input  logic            last_i,
  input  logic            found_i,
  input  logic [LENW-1:0] line_length_i,
  input  logic [TOTW-1:0] line_total_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              words_checked_o
);

  logic [7:0]      text_copy [DEPTH];
  ptr_t            wr_ptr;
  ptr_t            old_ptr;
  logic [TOTW-1:0] line_cnt;
  res_t            line_words_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    if (fail_count_o <= 100)
      $display("%0t: word %0d mismatch, %s: got %0d expected %0d",
               $time, words_checked_o, what, got, want);
  endtask

  task automatic push_word(input logic [7:0] ch, input logic lst, input logic fnd,
                           input logic [LENW-1:0] len);
    res_t w;
    w.out_char    = ch;
    w.last        = lst;
    w.found       = fnd;
    w.line_length = len;
    w.line_total  = line_cnt;
    line_words_q.push_back(w);
  endtask

  task automatic store_char(input logic [7:0] c_in);
    logic [7:0] c;
    ptr_t       held;
    bit         done;
    c = c_in;
    if (c == CH_CR) return;
    if (c == CH_LF) begin
      c = 8'd0;
      if (line_cnt != TOTAL_MAX) line_cnt++;
    end
    held = wr_ptr - old_ptr;
    if (held >= ptr_t'(DEPTH - 1)) begin
      // ring full: drop the oldest line through its terminator
      done = 1'b0;
      while (old_ptr != wr_ptr && !done) begin
        if (text_copy[old_ptr] == 8'd0) begin
          done = 1'b1;
          if (line_cnt != '0) line_cnt--;
        end
        old_ptr++;
      end
    end
    text_copy[wr_ptr] = c;
    wr_ptr++;
    text_copy[wr_ptr] = 8'd0;
  endtask

  task automatic predict_line_read(input logic [11:0] back_in, input logic [6:0] room_in);
    ptr_t            seek;
    ptr_t            head_pos;
    ptr_t            rd;
    logic [11:0]     back;
    logic [6:0]      room;
    logic [LENW-1:0] len;
    logic [7:0]      b;
    bit              skip, have, hit, ok, stop;
    back     = back_in;
    seek     = wr_ptr;
    head_pos = '0;
    skip     = 1'b1;
    have     = 1'b0;
    hit      = 1'b0;
    ok       = 1'b0;
    // walk back; the newest byte never ends a line
    while (seek != old_ptr && back != 12'd0 && !hit) begin
      seek = seek - 1'b1;
      if (!skip && text_copy[seek] == 8'd0) begin
        back = back - 1'b1;
        if (back == 12'd0) begin
          hit = 1'b1;
          ok  = have;
        end
      end
      if (!hit) begin
        skip     = 1'b0;
        head_pos = seek;
        have     = 1'b1;
      end
    end
    if (!hit && back == 12'd1) ok = have;
    if (!ok) begin
      push_word(8'd0, 1'b1, 1'b0, '0);
      return;
    end
    room = (room_in > MAX_READ) ? 7'(MAX_READ) : room_in;
    rd   = head_pos;
    len  = '0;
    stop = 1'b0;
    while (rd != wr_ptr && room > 7'd1 && !stop) begin
      b = text_copy[rd];
      room--;
      if (b == 8'd0) begin
        stop = 1'b1;
      end else begin
        push_word(b, 1'b0, 1'b1, '0);
        len++;
        rd++;
      end
    end
    push_word(8'd0, 1'b1, 1'b1, len);
  endtask

  task automatic check_word();
    res_t want;
    words_checked_o++;
    if (line_words_q.size() == 0) begin
      report_mismatch("word with no read pending, out_char", out_char_i, -1);
      return;
    end
    want = line_words_q.pop_front();
    if (out_char_i !== want.out_char)
      report_mismatch("out_char", out_char_i, want.out_char);
    if (last_i !== want.last)
      report_mismatch("last", last_i, want.last);
    if (found_i !== want.found)
      report_mismatch("found", found_i, want.found);
    if (line_length_i !== want.line_length)
      report_mismatch("line_length", line_length_i, want.line_length);
    if (line_total_i !== want.line_total)
      report_mismatch("line_total", line_total_i, want.line_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr   = '0;
      old_ptr  = '0;
      line_cnt = '0;
      line_words_q.delete();
      pending_o       = 0;
      fail_count_o    = 0;
      words_checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i) begin
        if (kind_i) predict_line_read(line_back_i, max_chars_i);
        else store_char(char_in_i);
      end
      pending_o = line_words_q.size();
    end
  end

endmodule

// ===== bench/tb_scrollback_line_ring_buffer.sv =====
// Testbench top for the scrollback line ring buffer: clock, reset, word stimulus,
// receiver stalls, watchdog and verdict. Checking is done by scrlb_checker.
// Depends on scrlb_pkg, scrlb_checker and the block under test.
`timescale 1ns / 1ps

module tb_scrollback_line_ring_buffer
  import scrlb_pkg::*;
();

  localparam int QUIET_LIMIT = 40000;
  localparam int RAND_ITEMS  = 410;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic            kind;
  logic [7:0]      char_in;
  logic [11:0]     line_back;
  logic [6:0]      max_chars;
  logic            out_valid;
  logic            out_stall;
  logic [7:0]      out_char;
  logic            word_last;
  logic            found;
  logic [LENW-1:0] line_length;
  logic [TOTW-1:0] line_total;

  int fail_count;
  int exp_pending;
  int words_checked;
  int n_appends;
  int n_reads;
  int quiet_cycles;
  bit src_idle_on;
  bit sink_idle_on;
  bit hold_go;
  bit hold_done;

  scrollback_line_ring_buffer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .char_in_i     (char_in),
    .line_back_i   (line_back),
    .max_chars_i   (max_chars),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_char_o    (out_char),
    .last_o        (word_last),
    .found_o       (found),
    .line_length_o (line_length),
    .line_total_o  (line_total)
  );

  scrlb_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .char_in_i       (char_in),
    .line_back_i     (line_back),
    .max_chars_i     (max_chars),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_char_i      (out_char),
    .last_i          (word_last),
    .found_i         (found),
    .line_length_i   (line_length),
    .line_total_i    (line_total),
    .fail_count_o    (fail_count),
    .pending_o       (exp_pending),
    .words_checked_o (words_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("scrollback_line_ring_buffer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = sink_idle_on && ($urandom_range(0, 99) < 26);
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic k, input logic [7:0] ch, input logic [11:0] back,
                           input logic [6:0] room);
    while (src_idle_on && $urandom_range(0, 99) < 26) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = k;
    char_in   = ch;
    line_back = back;
    max_chars = room;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k) n_reads++;
    else n_appends++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_word(1'b0, ch, 12'($urandom), 7'($urandom));
  endtask

  task automatic ask_line(input logic [11:0] back, input logic [6:0] room);
    send_word(1'b1, 8'($urandom), back, room);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (exp_pending != 0) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_back();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 12'($urandom_range(0, 6));
    if (r < 95) return 12'($urandom_range(7, 200));
    return 12'($urandom);
  endfunction

  initial begin
    int base;
    int line_len;
    bit paused;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    kind         = 1'b0;
    char_in      = 8'd0;
    line_back    = 12'd0;
    max_chars    = 7'd0;
    n_appends    = 0;
    n_reads      = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_go      = 1'b0;
    paused       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty ring, line zero, CR, unterminated tail, space limits, too far back
    ask_line(12'd1, 7'd64);
    ask_line(12'd0, 7'd64);
    put_char(CH_CR);
    ask_line(12'd1, 7'd64);
    put_char(8'd65);
    ask_line(12'd1, 7'd10);
    put_char(8'd255);
    put_char(8'd128);
    put_char(CH_LF);
    put_char(8'd98);
    put_char(CH_CR);
    put_char(CH_LF);
    put_char(8'd127);
    ask_line(12'd1, 7'd0);
    ask_line(12'd1, 7'd1);
    ask_line(12'd2, 7'd127);
    ask_line(12'd3, 7'd2);
    ask_line(12'd3, 7'd64);
    ask_line(12'd4, 7'd64);
    ask_line(12'd4095, 7'd64);
    ask_line(12'd2, 7'd3);
    wait_drained();
    @(negedge clk);

    // random lines with reads mixed in
    base = n_appends + n_reads;
    while (n_appends + n_reads - base < RAND_ITEMS) begin
      src_idle_on  = !((n_appends + n_reads - base) inside {[100:180]});
      sink_idle_on = src_idle_on;
      if (!paused && n_appends + n_reads - base >= 220) begin
        wait_drained();
        paused = 1'b1;
      end
      if (!hold_go && n_appends + n_reads - base >= 300) begin
        hold_go = 1'b1;
        for (int r = 0; r < 6; r++) ask_line(12'($urandom_range(1, 3)), 7'd64);
      end
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
      for (int j = 0; j < line_len; j++) begin
        if ($urandom_range(0, 9) == 0) put_char(8'($urandom));
        else put_char(8'($urandom_range(32, 126)));
      end
      if ($urandom_range(0, 4) == 0) put_char(CH_CR);
      if ($urandom_range(0, 9) != 0) put_char(CH_LF);
      repeat ($urandom_range(0, 2)) ask_line(pick_back(), 7'($urandom));
    end

    wait_drained();
    repeat (64) @(posedge clk);
    $display("Run covered %0d appends (CR, LF, unterminated tails, random bytes)",
             n_appends);
    $display("and %0d line reads, %0d result words compared", n_reads, words_checked);
    if (fail_count == 0) begin
      $display("scrollback_line_ring_buffer test passed");
    end else begin
      $display("scrollback_line_ring_buffer test failed");
    end
    $finish;
  end

endmodule
